FILE: sv/ir_level_sensor_poller_assert.svh
// Assertion macros used by the checker file of the IR level sensor poller.
`ifndef IR_LEVEL_SENSOR_POLLER_ASSERT_SVH
`define IR_LEVEL_SENSOR_POLLER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ILSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ILSP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/ilsp_pkg.sv
package ilsp_pkg;

  // Width of the reflection field on the result channel.
  localparam int unsigned REFL_W = 10;

  // Sample value latched in digital mode when the comparator bit is high.
  localparam logic [9:0] DIGITAL_HIGH_SAMPLE = 10'd505;

  // Register reset values.
  localparam logic [9:0]  THRESHOLD_RST      = 10'd405;
  localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd8;
  localparam logic [15:0] SETTLE_TICKS_RST   = 16'd10;
  localparam logic [15:0] POLL_TICKS_RST     = 16'd250;
  localparam logic        LED_ALWAYS_ON_RST  = 1'b0;
  localparam logic        ANALOG_MODE_RST    = 1'b1;

  // Sequencer phases.
  typedef enum logic [1:0] {
    PH_LED_ON = 2'd0,
    PH_START  = 2'd1,
    PH_SAMPLE = 2'd2
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_THRESHOLD      = 3'd0,
    REG_DEBOUNCE_LIMIT = 3'd1,
    REG_SETTLE_TICKS   = 3'd2,
    REG_POLL_TICKS     = 3'd3,
    REG_LED_ALWAYS_ON  = 3'd4,
    REG_ANALOG_MODE    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]  threshold;
    logic [7:0]  debounce_limit;
    logic [15:0] settle_ticks;
    logic [15:0] poll_ticks;
    logic        led_always_on;
    logic        analog_mode;
  } cfg_t;

  typedef struct packed {
    logic       tick;
    logic       adc_done;
    logic [9:0] adc_value;
    logic       sensor_bit;
    logic       filling;
  } item_t;

  typedef struct packed {
    logic       led_on;
    logic       adc_start;
    logic       detected;
    logic       event_pulse;
    logic [9:0] reflection;
    logic       valve_pullup;
  } res_t;

endpackage

FILE: sv/ilsp_step.sv
module ilsp_step #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  ilsp_pkg::item_t item,
  input  ilsp_pkg::cfg_t  cfg,
  output ilsp_pkg::res_t  res
);

  localparam int CMP_W = (SAMPLE_BITS > ilsp_pkg::REFL_W) ? SAMPLE_BITS
                                                           : ilsp_pkg::REFL_W;

  ilsp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] wait_r, wait_nxt, wait_dec;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        det_r, det_nxt;
  logic        led_r, led_nxt;
  logic [SAMPLE_BITS-1:0] latch_r, latch_nxt;

  logic       expired;
  logic       ready;
  logic [9:0] raw_sample;
  logic       start;
  logic       event_hit;

  // Timer decrements on a tick before the phase logic looks at it.
  always_comb begin
    wait_dec = (item.tick && (wait_r != 16'd0)) ? wait_r - 16'd1 : wait_r;
    expired  = (wait_dec == 16'd0);
    ready    = cfg.analog_mode ? item.adc_done : expired;
    raw_sample = cfg.analog_mode ? item.adc_value
                                 : (item.sensor_bit ? ilsp_pkg::DIGITAL_HIGH_SAMPLE
                                                    : 10'd0);
  end

  // Next phase of the sequencer; the unused code behaves as LED on.
  always_comb begin
    case (phase_r)
      ilsp_pkg::PH_START: begin
        phase_nxt = expired ? ilsp_pkg::PH_SAMPLE : ilsp_pkg::PH_START;
      end
      ilsp_pkg::PH_SAMPLE: begin
        phase_nxt = ready ? ilsp_pkg::PH_LED_ON : ilsp_pkg::PH_SAMPLE;
      end
      default: begin
        if (expired) begin
          phase_nxt = cfg.analog_mode ? ilsp_pkg::PH_START : ilsp_pkg::PH_SAMPLE;
        end else begin
          phase_nxt = ilsp_pkg::PH_LED_ON;
        end
      end
    endcase
  end

  // Timer loads, LED drive, sample latch and debounce counter.
  always_comb begin
    wait_nxt  = wait_dec;
    led_nxt   = led_r;
    latch_nxt = latch_r;
    cnt_nxt   = cnt_r;
    det_nxt   = det_r;
    start     = 1'b0;
    event_hit = 1'b0;
    case (phase_r)
      ilsp_pkg::PH_START: begin
        start = expired;
      end
      ilsp_pkg::PH_SAMPLE: begin
        if (ready) begin
          latch_nxt = SAMPLE_BITS'(raw_sample);
          if (!item.filling && !cfg.led_always_on) begin
            led_nxt = 1'b0;
          end
          if (CMP_W'(latch_nxt) <= CMP_W'(cfg.threshold)) begin
            if (cnt_r != 8'd0) begin
              cnt_nxt = cnt_r - 8'd1;
              if ((cnt_nxt == 8'd0) && det_r) begin
                det_nxt   = 1'b0;
                event_hit = 1'b1;
              end
            end
          end else begin
            if (cnt_r < cfg.debounce_limit) begin
              cnt_nxt = cnt_r + 8'd1;
              if ((cnt_nxt >= cfg.debounce_limit) && !det_r) begin
                det_nxt   = 1'b1;
                event_hit = 1'b1;
              end
            end
          end
          wait_nxt = cfg.poll_ticks;
        end
      end
      default: begin
        if (expired) begin
          led_nxt  = 1'b1;
          wait_nxt = cfg.settle_ticks;
        end
      end
    endcase
  end

  // Result of this step, taken by the output register in the top level.
  always_comb begin
    res.led_on       = led_nxt;
    res.adc_start    = start;
    res.detected     = det_nxt;
    res.event_pulse  = event_hit;
    res.reflection   = ilsp_pkg::REFL_W'(latch_nxt);
    res.valve_pullup = item.filling;
  end

  // Sequencer state advances once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ilsp_pkg::PH_LED_ON;
      wait_r  <= 16'd0;
      cnt_r   <= 8'd0;
      det_r   <= 1'b0;
      led_r   <= 1'b0;
      latch_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      cnt_r   <= cnt_nxt;
      det_r   <= det_nxt;
      led_r   <= led_nxt;
      latch_r <= latch_nxt;
    end
  end

endmodule

FILE: sv/ir_level_sensor_poller.sv
// IR level sensor poller.
// Each request on the in_ channel is one polling step: a timer tick flag, the
// ADC handshake and value, the digital sensor bit and the valve command. Each
// step produces exactly one request on the out_ channel carrying the LED drive,
// the ADC start pulse, the debounced detected flag, the change event, the last
// latched reflection sample and the valve pull-up drive.
// A request sits in the input register, then the step logic updates the
// sequencer and writes the output register. Throughput is one request per cycle
// while the receiver does not stall; the step is a single pass through the
// timer decrement, the threshold compare and the debounce counter update.
// When the receiver stalls, the output register holds its result and the input
// register keeps one more request; in_tready falls only when both are full.
// Reset (rst_n low, synchronous) empties both registers, puts the sequencer in the
// LED-on phase with an expired timer and loads the register defaults. The cfg_
// channel is always ready; users write it only while idle, as nothing checks it.
module ir_level_sensor_poller #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tick[0], adc_done[1], adc_value[11:2], sensor_bit[12], filling[13], zero[15:14]
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // led_on[0], adc_start[1], detected[2], event_pulse[3], reflection[13:4],
  // valve_pullup[14], zero[15]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ilsp_pkg::cfg_t  cfg_r;
  ilsp_pkg::item_t s1_item_r;
  logic            s1_valid_r, s1_valid_nxt;
  ilsp_pkg::res_t  out_res_r;
  logic            out_valid_r, out_valid_nxt;
  ilsp_pkg::res_t  step_res;

  logic out_free;
  logic advance;
  logic in_accept;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= ilsp_pkg::THRESHOLD_RST;
      cfg_r.debounce_limit <= ilsp_pkg::DEBOUNCE_LIMIT_RST;
      cfg_r.settle_ticks   <= ilsp_pkg::SETTLE_TICKS_RST;
      cfg_r.poll_ticks     <= ilsp_pkg::POLL_TICKS_RST;
      cfg_r.led_always_on  <= ilsp_pkg::LED_ALWAYS_ON_RST;
      cfg_r.analog_mode    <= ilsp_pkg::ANALOG_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ilsp_pkg::reg_idx_t'(cfg_index))
        ilsp_pkg::REG_THRESHOLD:      cfg_r.threshold      <= cfg_data[9:0];
        ilsp_pkg::REG_DEBOUNCE_LIMIT: cfg_r.debounce_limit <= cfg_data[7:0];
        ilsp_pkg::REG_SETTLE_TICKS:   cfg_r.settle_ticks   <= cfg_data;
        ilsp_pkg::REG_POLL_TICKS:     cfg_r.poll_ticks     <= cfg_data;
        ilsp_pkg::REG_LED_ALWAYS_ON:  cfg_r.led_always_on  <= cfg_data[0];
        ilsp_pkg::REG_ANALOG_MODE:    cfg_r.analog_mode    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control: the step runs when the output register can take it.
  always_comb begin
    out_free      = !out_valid_r || out_tready;
    advance       = s1_valid_r && out_free;
    in_tready     = !s1_valid_r || out_free;
    in_accept     = in_tvalid && in_tready;
    s1_valid_nxt  = in_accept || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.tick       <= in_tdata[0];
      s1_item_r.adc_done   <= in_tdata[1];
      s1_item_r.adc_value  <= in_tdata[11:2];
      s1_item_r.sensor_bit <= in_tdata[12];
      s1_item_r.filling    <= in_tdata[13];
    end
  end

  ilsp_step #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       out_res_r.valve_pullup,
                       out_res_r.reflection,
                       out_res_r.event_pulse,
                       out_res_r.detected,
                       out_res_r.adc_start,
                       out_res_r.led_on};

endmodule

FILE: sv/ilsp_checker.sv
`include "ir_level_sensor_poller_assert.svh"

module ilsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result holds its value.
  `ILSP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // The output register is empty in the cycle after reset.
  `ILSP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // With no result waiting, the input side is never blocked.
  `ILSP_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input blocked with empty output")

  // A conversion is only started while the LED is lit.
  `ILSP_ASSERT(a_start_led, clk, rst_n, out_tvalid && out_tdata[1] |-> out_tdata[0], "adc start with LED off")

  // A start pulse and a detected change never come from the same step.
  `ILSP_ASSERT(a_start_event, clk, rst_n, out_tvalid |-> !(out_tdata[1] && out_tdata[3]), "start and event together")

endmodule

bind ir_level_sensor_poller ilsp_checker u_ilsp_checker (.*);

FILE: dv/tb_ir_level_sensor_poller.sv
`timescale 1ns / 1ps

module tb_ir_level_sensor_poller;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // Shadow of the poller: its own register copy, sequencer state and the
  // queue of step results still owed by the block.
  class poll_scoreboard;
    logic [9:0]  threshold;
    logic [7:0]  deb_limit;
    logic [15:0] settle_ticks;
    logic [15:0] poll_ticks;
    logic        led_always_on;
    logic        analog_mode;

    ilsp_pkg::phase_t phase;
    logic [15:0] wait_cnt;
    logic [7:0]  deb_cnt;
    logic        detected;
    logic [9:0]  latch;
    logic        led;

    ilsp_pkg::res_t expected_polls[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      threshold     = ilsp_pkg::THRESHOLD_RST;
      deb_limit     = ilsp_pkg::DEBOUNCE_LIMIT_RST;
      settle_ticks  = ilsp_pkg::SETTLE_TICKS_RST;
      poll_ticks    = ilsp_pkg::POLL_TICKS_RST;
      led_always_on = ilsp_pkg::LED_ALWAYS_ON_RST;
      analog_mode   = ilsp_pkg::ANALOG_MODE_RST;
      phase         = ilsp_pkg::PH_LED_ON;
      wait_cnt      = '0;
      deb_cnt       = '0;
      detected      = 1'b0;
      latch         = '0;
      led           = 1'b0;
      errors        = 0;
      results_seen  = 0;
    endfunction

    function void set_reg(ilsp_pkg::reg_idx_t idx, logic [15:0] value);
      case (idx)
        ilsp_pkg::REG_THRESHOLD:      threshold = value[9:0];
        ilsp_pkg::REG_DEBOUNCE_LIMIT: deb_limit = value[7:0];
        ilsp_pkg::REG_SETTLE_TICKS:   settle_ticks = value;
        ilsp_pkg::REG_POLL_TICKS:     poll_ticks = value;
        ilsp_pkg::REG_LED_ALWAYS_ON:  led_always_on = value[0];
        ilsp_pkg::REG_ANALOG_MODE:    analog_mode = value[0];
        default: ;
      endcase
    endfunction

    // One step of the sequencer: timer, phase action, debounce update.
    function ilsp_pkg::res_t predict_poll_step(ilsp_pkg::item_t it);
      ilsp_pkg::res_t r;
      logic       expired;
      logic       take;
      logic [9:0] s;
      r = '0;
      if (it.tick && wait_cnt != 16'd0)
        wait_cnt = wait_cnt - 16'd1;
      expired = (wait_cnt == 16'd0);
      case (phase)
        ilsp_pkg::PH_START: begin
          if (expired) begin
            r.adc_start = 1'b1;
            phase = ilsp_pkg::PH_SAMPLE;
          end
        end
        ilsp_pkg::PH_SAMPLE: begin
          take = analog_mode ? it.adc_done : expired;
          if (take) begin
            s = analog_mode ? it.adc_value
                            : (it.sensor_bit ? ilsp_pkg::DIGITAL_HIGH_SAMPLE : 10'd0);
            latch = s;
            if (!it.filling && !led_always_on)
              led = 1'b0;
            if (latch <= threshold) begin
              // Dry sample: count down, clear the flag on reaching zero.
              if (deb_cnt > 8'd0) begin
                deb_cnt = deb_cnt - 8'd1;
                if (deb_cnt == 8'd0 && detected) begin
                  detected = 1'b0;
                  r.event_pulse = 1'b1;
                end
              end
            end else begin
              // Wet sample: count up only while below the limit.
              if (deb_cnt < deb_limit) begin
                deb_cnt = deb_cnt + 8'd1;
                if (deb_cnt >= deb_limit && !detected) begin
                  detected = 1'b1;
                  r.event_pulse = 1'b1;
                end
              end
            end
            wait_cnt = poll_ticks;
            phase = ilsp_pkg::PH_LED_ON;
          end
        end
        default: begin
          // LED-on phase; an unused code behaves the same way.
          if (expired) begin
            led = 1'b1;
            wait_cnt = settle_ticks;
            phase = analog_mode ? ilsp_pkg::PH_START : ilsp_pkg::PH_SAMPLE;
          end
        end
      endcase
      r.led_on       = led;
      r.detected     = detected;
      r.reflection   = latch;
      r.valve_pullup = it.filling;
      return r;
    endfunction

    function void note_input(logic [15:0] d);
      ilsp_pkg::item_t it;
      it.tick       = d[0];
      it.adc_done   = d[1];
      it.adc_value  = d[11:2];
      it.sensor_bit = d[12];
      it.filling    = d[13];
      expected_polls.push_back(predict_poll_step(it));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
      errors++;
    endtask

    task check_result(logic [15:0] d);
      ilsp_pkg::res_t want;
      if (expected_polls.size() == 0) begin
        report_mismatch($sformatf("unexpected result %04h", d));
      end else begin
        want = expected_polls.pop_front();
        if (d[0] !== want.led_on)
          report_mismatch($sformatf("led_on %b, want %b", d[0], want.led_on));
        if (d[1] !== want.adc_start)
          report_mismatch($sformatf("adc_start %b, want %b", d[1], want.adc_start));
        if (d[2] !== want.detected)
          report_mismatch($sformatf("detected %b, want %b", d[2], want.detected));
        if (d[3] !== want.event_pulse)
          report_mismatch($sformatf("event_pulse %b, want %b", d[3], want.event_pulse));
        if (d[13:4] !== want.reflection)
          report_mismatch($sformatf("reflection %0d, want %0d", d[13:4], want.reflection));
        if (d[14] !== want.valve_pullup)
          report_mismatch($sformatf("valve_pullup %b, want %b", d[14], want.valve_pullup));
      end
      results_seen++;
    endtask

    function int pending();
      return expected_polls.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // tick[0], adc_done[1], adc_value[11:2], sensor_bit[12], filling[13], zero[15:14]
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // led_on[0], adc_start[1], detected[2], event_pulse[3], reflection[13:4],
  // valve_pullup[14], zero[15]
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  ilsp_pkg::reg_idx_t cfg_index = ilsp_pkg::REG_THRESHOLD;
  logic [15:0] cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_cnt = 0;
  poll_scoreboard sb;

  ir_level_sensor_poller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Watch both channels; predictions are made in acceptance order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
    end
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task send_poll(input logic [15:0] word);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task poll(input logic tick, input logic done, input logic [9:0] val,
            input logic sbit, input logic fill);
    send_poll({2'b00, fill, sbit, val, done, tick});
  endtask

  // Hold the sender back until the block has returned every result.
  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(input ilsp_pkg::reg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // New settings for a block of random steps. Most timer loads are short so
  // that many samples get taken; the longest loads only come at the very end,
  // since they freeze the sequencer for the rest of the run.
  task configure_block(input bit last_block);
    int unsigned r;
    if ($urandom_range(9, 0) < 6) begin
      r = $urandom_range(99, 0);
      write_reg(ilsp_pkg::REG_THRESHOLD,
                (r < 10) ? 16'd0 : (r < 20) ? 16'd1023 : 16'($urandom_range(1023, 0)));
    end
    if ($urandom_range(9, 0) < 6) begin
      r = $urandom_range(99, 0);
      write_reg(ilsp_pkg::REG_DEBOUNCE_LIMIT,
                (r < 10) ? 16'd0 : (r < 20) ? 16'd255 : 16'($urandom_range(6, 1)));
    end
    if (last_block || $urandom_range(9, 0) < 6)
      write_reg(ilsp_pkg::REG_SETTLE_TICKS,
                last_block ? 16'hFFFF : 16'($urandom_range(4, 0)));
    if (last_block || $urandom_range(9, 0) < 6)
      write_reg(ilsp_pkg::REG_POLL_TICKS,
                last_block ? 16'hFFFF : 16'($urandom_range(4, 0)));
    if ($urandom_range(9, 0) < 6)
      write_reg(ilsp_pkg::REG_LED_ALWAYS_ON, 16'($urandom_range(1, 0)));
    if ($urandom_range(9, 0) < 6)
      write_reg(ilsp_pkg::REG_ANALOG_MODE, 16'($urandom_range(1, 0)));
  endtask

  // Bursts of mostly wet or mostly dry readings, so the debounce counter
  // walks all the way to the limit and back; the rest is plain noise.
  task run_block(input int n_items);
    int         burst_left;
    logic       wet;
    logic       fill;
    logic       tick;
    logic       done;
    logic       sbit;
    logic [9:0] val;
    burst_left = 0;
    wet = 1'b0;
    fill = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 5);
        wet = 1'($urandom_range(1, 0));
        fill = ($urandom_range(3, 0) == 0);
      end
      burst_left--;
      tick = ($urandom_range(9, 0) < 7);
      done = ($urandom_range(9, 0) < 4);
      if ($urandom_range(99, 0) < 85) begin
        if (wet && sb.threshold != 10'h3FF)
          val = 10'($urandom_range(1023, sb.threshold + 1));
        else if (!wet)
          val = 10'($urandom_range(sb.threshold, 0));
        else
          val = 10'($urandom_range(1023, 0));
        sbit = wet;
      end else begin
        val = 10'($urandom_range(1023, 0));
        sbit = 1'($urandom_range(1, 0));
      end
      poll(tick, done, val, sbit, fill);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 87;

    // Out of reset: the LED lights at once, then an all-ones input while the timer runs.
    poll(1'b0, 1'b0, 10'd0, 1'b0, 1'b0);
    poll(1'b1, 1'b1, 10'd1023, 1'b1, 1'b1);

    // Analog cycle with zero-length timers and a limit of one.
    drain();
    write_reg(ilsp_pkg::REG_THRESHOLD, 16'd0);
    write_reg(ilsp_pkg::REG_DEBOUNCE_LIMIT, 16'd1);
    write_reg(ilsp_pkg::REG_SETTLE_TICKS, 16'd0);
    write_reg(ilsp_pkg::REG_POLL_TICKS, 16'd0);
    write_reg(ilsp_pkg::REG_LED_ALWAYS_ON, 16'd0);
    write_reg(ilsp_pkg::REG_ANALOG_MODE, 16'd1);
    // Let the settle load from the reset value run out, ticking every step.
    repeat (10) poll(1'b1, 1'b0, 10'd512, 1'b0, 1'b0);
    // Full-scale sample while filling: detected rises, LED stays lit.
    poll(1'b1, 1'b1, 10'd1023, 1'b0, 1'b1);
    poll(1'b0, 1'b0, 10'd0, 1'b0, 1'b0);
    poll(1'b0, 1'b0, 10'd0, 1'b0, 1'b0);
    // Zero sample, not filling: detected falls and the LED goes off.
    poll(1'b0, 1'b1, 10'd0, 1'b0, 1'b0);

    // Digital mode around the fixed high level, LED held on.
    drain();
    write_reg(ilsp_pkg::REG_ANALOG_MODE, 16'd0);
    write_reg(ilsp_pkg::REG_THRESHOLD, 16'd504);
    write_reg(ilsp_pkg::REG_LED_ALWAYS_ON, 16'd1);
    poll(1'b0, 1'b0, 10'd0, 1'b1, 1'b0);
    poll(1'b0, 1'b0, 10'd0, 1'b1, 1'b0);
    poll(1'b1, 1'b1, 10'd1023, 1'b0, 1'b0);
    poll(1'b1, 1'b1, 10'd1023, 1'b0, 1'b0);
    // Sensor high exactly at the threshold does not count as wet.
    drain();
    write_reg(ilsp_pkg::REG_THRESHOLD, 16'd505);
    poll(1'b0, 1'b0, 10'd0, 1'b1, 1'b1);
    poll(1'b0, 1'b0, 10'd0, 1'b1, 1'b1);

    // Random blocks under three idling patterns.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 14; recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int b = 0; b < 5; b++) begin
        drain();
        configure_block(ph == 2 && b == 4);
        run_block(105);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
